// ----- design/hsvr_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvr_pkg: shared types and helpers for the rainbow HSV to RGB converter
// Transaction payloads, the classified item that sits in the queue, the
// rainbow segment codes and the 8-bit scale helper.
// ----------------------------------------------------------------------------
package hsvr_pkg;

   // Input transaction
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsvr_req_type;

   // Result transaction
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsvr_rsp_type;

   // Classified item: base segment color plus the two scale factors
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsvr_item_type;

   // Queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
   } hsvr_qstat_type;

   // Rainbow segments picked by the top three hue bits
   typedef enum logic [2:0] {
      SEG_RED_ORANGE    = 3'd0,
      SEG_ORANGE_YELLOW = 3'd1,
      SEG_YELLOW_GREEN  = 3'd2,
      SEG_GREEN_AQUA    = 3'd3,
      SEG_AQUA_BLUE     = 3'd4,
      SEG_BLUE_PURPLE   = 3'd5,
      SEG_PURPLE_PINK   = 3'd6,
      SEG_PINK_RED      = 3'd7
   } hsvr_seg_type;

   localparam logic [7:0] THIRD_MUL  = 8'd86;
   localparam logic [7:0] TWOTH_MUL  = 8'd171;
   localparam logic [7:0] LEVEL_FULL = 8'd255;
   localparam logic [7:0] LEVEL_2_3  = 8'd171;
   localparam logic [7:0] LEVEL_2_3L = 8'd170;
   localparam logic [7:0] LEVEL_1_3  = 8'd85;

   // scale8: (x * (1 + s)) >> 8, always fits in 8 bits
   function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] s);
      logic [16:0] prod;
      prod = {9'd0, x} * ({9'd0, s} + 17'd1);
      return prod[15:8];
   endfunction

endpackage

// ----- design/hsv_rainbow_to_rgb.sv -----
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb: rainbow HSV to RGB converter
// Classifier, two-entry queue and two-stage scaler.
// ----------------------------------------------------------------------------
// One transaction can be started every clock. A transaction taken at an edge
// (start high, busy low) is written into the queue register, passes the two
// scaler stages and then shows its color on rsp_data with rsp_strobe high.
// Results come in order, one per transaction. The receiver cannot stall, so
// the scaler drains the queue every cycle and busy is high only during reset.
// ----------------------------------------------------------------------------
module hsv_rainbow_to_rgb import hsvr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  hsvr_req_type req_data,
   output logic         rsp_strobe,
   output hsvr_rsp_type rsp_data
);

   hsvr_item_type  front_item;
   hsvr_item_type  queue_item;
   hsvr_qstat_type queue_stat;
   logic           accept;

   assign busy   = queue_stat.full || reset;
   assign accept = start && !busy;

   // Classify hue into a base segment color
   hsvr_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   // Queue between front and back
   hsvr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (!queue_stat.empty),
      .pop_item  (queue_item),
      .status    (queue_stat)
   );

   // Saturation and brightness scaling
   hsvr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_stat.empty),
      .item       (queue_item),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Every accepted transaction gives a result after fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // The scaler drains the queue every cycle, so it never fills
   a_never_full: assert property (@(posedge clock) disable iff (reset)
      !queue_stat.full)
      else $error("queue filled up");

   // Zero saturation at full brightness gives white
   a_white: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.saturation == 8'd0 && req_data.brightness == LEVEL_FULL)
      |-> ##3 (rsp_data.red == LEVEL_FULL && rsp_data.green == LEVEL_FULL
               && rsp_data.blue == LEVEL_FULL))
      else $error("zero saturation did not give white");

   // Zero brightness gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.brightness == 8'd0)
      |-> ##3 (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0))
      else $error("zero brightness did not give black");

endmodule

// ----- design/hsvr_front.sv -----
// ----------------------------------------------------------------------------
// hsvr_front: hue classifier
// Splits the hue into segment and offset and builds the piecewise-linear
// base color of that segment.
// ----------------------------------------------------------------------------
module hsvr_front import hsvr_pkg::*; (
   input  hsvr_req_type  req_data,
   output hsvr_item_type item
);

   logic [4:0]   offset;
   logic [11:0]  third_prod;
   logic [12:0]  twoth_prod;
   logic [7:0]   third;
   logic [7:0]   twoth;
   hsvr_seg_type seg;

   // Offset ramps: off*86/32 and off*171/32, truncated
   assign offset     = req_data.hue[4:0];
   assign seg        = hsvr_seg_type'(req_data.hue[7:5]);
   assign third_prod = {7'd0, offset} * {4'd0, THIRD_MUL};
   assign twoth_prod = {8'd0, offset} * {5'd0, TWOTH_MUL};
   assign third      = {1'b0, third_prod[11:5]};
   assign twoth      = twoth_prod[12:5];

   // Segment base color
   always_comb begin
      item.saturation = req_data.saturation;
      item.brightness = req_data.brightness;
      case (seg)
         SEG_RED_ORANGE: begin
            item.red = LEVEL_FULL - third; item.green = third;              item.blue = 8'd0;
         end
         SEG_ORANGE_YELLOW: begin
            item.red = LEVEL_2_3;          item.green = LEVEL_1_3 + third;  item.blue = 8'd0;
         end
         SEG_YELLOW_GREEN: begin
            item.red = LEVEL_2_3 - twoth;  item.green = LEVEL_2_3L + third; item.blue = 8'd0;
         end
         SEG_GREEN_AQUA: begin
            item.red = 8'd0;               item.green = LEVEL_FULL - third; item.blue = third;
         end
         SEG_AQUA_BLUE: begin
            item.red = 8'd0;               item.green = LEVEL_2_3 - twoth;
            item.blue = LEVEL_1_3 + twoth;
         end
         SEG_BLUE_PURPLE: begin
            item.red = third;              item.green = 8'd0;
            item.blue = LEVEL_FULL - third;
         end
         SEG_PURPLE_PINK: begin
            item.red = LEVEL_1_3 + third;  item.green = 8'd0;
            item.blue = LEVEL_2_3 - third;
         end
         default: begin
            item.red = LEVEL_2_3L + third; item.green = 8'd0;
            item.blue = LEVEL_1_3 - third;
         end
      endcase
   end

endmodule

// ----- design/hsvr_queue.sv -----
// ----------------------------------------------------------------------------
// hsvr_queue: two-entry queue between classifier and scaler
// Decouples the accept side from the scaling pipeline.
// ----------------------------------------------------------------------------
module hsvr_queue import hsvr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  hsvr_item_type  push_item,
   input  logic           pop,
   output hsvr_item_type  pop_item,
   output hsvr_qstat_type status
);

   hsvr_item_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff,  count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/hsvr_back.sv -----
// ----------------------------------------------------------------------------
// hsvr_back: saturation and brightness scaler
// Stage one applies saturation and the white floor, stage two applies
// brightness and drives the result strobe.
// ----------------------------------------------------------------------------
module hsvr_back import hsvr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  hsvr_item_type item,
   output logic          rsp_strobe,
   output hsvr_rsp_type  rsp_data
);

   logic         s1_valid_ff, s1_valid_in;
   hsvr_rsp_type s1_color_ff, s1_color_in;
   logic [7:0]   s1_bright_ff;
   logic         out_valid_ff, out_valid_in;
   hsvr_rsp_type out_color_ff, out_color_in;
   logic [7:0]   desat;
   logic [7:0]   floor_w;

   // Saturation: scale8 of zero stays zero and full saturation is identity,
   // and zero saturation (white) is given its own path
   assign desat   = LEVEL_FULL - item.saturation;
   assign floor_w = scale8(desat, desat);

   always_comb begin
      s1_valid_in = item_valid;
      if (item.saturation == 8'd0) begin
         s1_color_in = '{red: LEVEL_FULL, green: LEVEL_FULL, blue: LEVEL_FULL};
      end else begin
         s1_color_in.red   = scale8(item.red,   item.saturation) + floor_w;
         s1_color_in.green = scale8(item.green, item.saturation) + floor_w;
         s1_color_in.blue  = scale8(item.blue,  item.saturation) + floor_w;
      end
   end

   // Brightness: zero gives black and full is identity through scale8
   always_comb begin
      out_valid_in       = s1_valid_ff;
      out_color_in.red   = scale8(s1_color_ff.red,   s1_bright_ff);
      out_color_in.green = scale8(s1_color_ff.green, s1_bright_ff);
      out_color_in.blue  = scale8(s1_color_ff.blue,  s1_bright_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_color_ff  <= s1_color_in;
      s1_bright_ff <= item.brightness;
      out_color_ff <= out_color_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_color_ff;

endmodule

// ----- bench/hsvr_color_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_color_checker: result checker for the rainbow HSV to RGB converter
// Watches the request and result channels. Each accepted request is turned
// into its expected color, and each strobed result is checked against the
// oldest waiting color. Mismatches and unexpected results go to fail_count.
// ----------------------------------------------------------------------------
module hsvr_color_checker import hsvr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  hsvr_req_type req_data,
   input  logic         rsp_strobe,
   input  hsvr_rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   localparam int REPORT_LIMIT = 10;

   hsvr_rsp_type expected_colors[$];

   // (x * (1 + s)) >> 8
   function automatic logic [7:0] scale_level(input logic [7:0] x, input logic [7:0] s);
      logic [15:0] prod;
      prod = 16'(x) * (16'(s) + 16'd1);
      return prod[15:8];
   endfunction

   // Expected color for one pixel
   function automatic hsvr_rsp_type rainbow_color(input hsvr_req_type px);
      logic [15:0]  offs;
      logic [7:0]   third;
      logic [7:0]   twoth;
      logic [7:0]   r;
      logic [7:0]   g;
      logic [7:0]   b;
      logic [7:0]   d;
      logic [7:0]   floor_w;
      hsvr_seg_type seg;
      hsvr_rsp_type color;
      offs  = 16'(px.hue[4:0]);
      third = 8'((offs * 16'd86) >> 5);
      twoth = 8'((offs * 16'd171) >> 5);
      seg   = hsvr_seg_type'(px.hue[7:5]);
      // base ramps per segment
      case (seg)
         SEG_RED_ORANGE: begin
            r = 8'd255 - third; g = third;             b = 8'd0;
         end
         SEG_ORANGE_YELLOW: begin
            r = 8'd171;         g = 8'd85 + third;     b = 8'd0;
         end
         SEG_YELLOW_GREEN: begin
            r = 8'd171 - twoth; g = 8'd170 + third;    b = 8'd0;
         end
         SEG_GREEN_AQUA: begin
            r = 8'd0;           g = 8'd255 - third;    b = third;
         end
         SEG_AQUA_BLUE: begin
            r = 8'd0;           g = 8'd171 - twoth;    b = 8'd85 + twoth;
         end
         SEG_BLUE_PURPLE: begin
            r = third;          g = 8'd0;              b = 8'd255 - third;
         end
         SEG_PURPLE_PINK: begin
            r = 8'd85 + third;  g = 8'd0;              b = 8'd171 - third;
         end
         default: begin
            r = 8'd170 + third; g = 8'd0;              b = 8'd85 - third;
         end
      endcase
      // desaturate toward white; the floor wraps mod 256
      if (px.saturation != 8'd255) begin
         if (px.saturation == 8'd0) begin
            r = 8'd255; g = 8'd255; b = 8'd255;
         end else begin
            d       = 8'd255 - px.saturation;
            floor_w = scale_level(d, d);
            if (r != 8'd0) r = scale_level(r, px.saturation);
            if (g != 8'd0) g = scale_level(g, px.saturation);
            if (b != 8'd0) b = scale_level(b, px.saturation);
            r = r + floor_w;
            g = g + floor_w;
            b = b + floor_w;
         end
      end
      // dim by brightness
      if (px.brightness != 8'd255) begin
         if (px.brightness == 8'd0) begin
            r = 8'd0; g = 8'd0; b = 8'd0;
         end else begin
            if (r != 8'd0) r = scale_level(r, px.brightness);
            if (g != 8'd0) g = scale_level(g, px.brightness);
            if (b != 8'd0) b = scale_level(b, px.brightness);
         end
      end
      color.red   = r;
      color.green = g;
      color.blue  = b;
      return color;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Compare strobed results, then record newly accepted transactions
   always @(posedge clock) begin : watch
      hsvr_rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_colors.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                           rsp_data.red, rsp_data.green, rsp_data.blue);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_colors.push_back(rainbow_color(req_data));
         pending_count <= expected_colors.size();
      end
   end

endmodule

// ----- bench/hsv_rainbow_to_rgb_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rainbow_to_rgb_test: testbench for the rainbow HSV to RGB converter
// Sends a directed set of corner pixels and then random pixels with random
// gaps and gap-free bursts. A checker beside the block predicts each color
// and counts failures; the top gives the verdict.
// ----------------------------------------------------------------------------
module hsv_rainbow_to_rgb_test;
   import hsvr_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int MAX_GAP      = 16;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   hsvr_req_type req_data;
   logic         rsp_strobe;
   hsvr_rsp_type rsp_data;
   int           fail_count;
   int           pending_count;
   bit           no_gaps;

   hsv_rainbow_to_rgb i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   hsvr_color_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #1ms;
      $display("Simulation FAILED");
      $finish;
   end

   // One pixel transaction, then an optional idle gap
   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      start               <= 1'b1;
      req_data.hue        <= hue;
      req_data.saturation <= sat;
      req_data.brightness <= val;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every expected color has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Level with extra weight on the full and zero ends
   function automatic logic [7:0] pick_level();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 8'd0;
      if (roll <= 2) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   // Stimulus
   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      no_gaps   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // each segment at both ends of its offset range, full color
      for (int seg = 0; seg < 8; seg++) begin
         send_pixel({3'(seg), 5'd0}, 8'd255, 8'd255);
         send_pixel({3'(seg), 5'd31}, 8'd255, 8'd255);
      end
      send_pixel(8'h00, 8'd0, 8'd255);     // white
      send_pixel(8'h40, 8'd255, 8'd0);     // black
      send_pixel(8'h55, 8'd0, 8'd0);       // white then black
      send_pixel(8'h00, 8'd1, 8'd1);       // lowest nonzero levels
      send_pixel(8'h9F, 8'd254, 8'd254);   // just below full
      send_pixel(8'h00, 8'd128, 8'd200);   // zero channels get only the floor
      send_pixel(8'hFF, 8'd1, 8'd255);     // floor near its largest
      send_pixel(8'hAA, 8'd255, 8'd1);
      drain();

      // random pixels; every 40 items choose gap-free burst or random gaps
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         if (i == RANDOM_ITEMS / 2) drain();
         send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
      end
      drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/hsvr_pkg.sv
design/hsvr_front.sv
design/hsvr_queue.sv
design/hsvr_back.sv
design/hsv_rainbow_to_rgb.sv
bench/hsvr_color_checker.sv
bench/hsv_rainbow_to_rgb_test.sv
